// ===== sv/per_key_cooldown_tap_pulser_defines.svh =====
// Assertion macros used by the block's datapath module.
`ifndef PER_KEY_COOLDOWN_TAP_PULSER_DEFINES_SVH
`define PER_KEY_COOLDOWN_TAP_PULSER_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define PKCTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define PKCTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pkctp_pkg.sv =====
package pkctp_pkg;

	localparam int POSITIONS = 64;
	localparam int IDX_W     = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
	localparam int CNT_W     = IDX_W + 1;

	localparam int TIME_W    = 32;
	localparam int CODE_W    = 32;
	localparam int POS_W     = 6;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] COOLDOWN_RST = 16'd50;
	localparam logic [CFG_W-1:0] TAP_LEN_RST  = 16'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_LEN  = 1'd1;

	localparam logic FUNC_PRESS = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [POS_W-1:0]  position;
		logic [CODE_W-1:0] keycode;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0] out_keycode;
		logic              is_press;
		logic [TIME_W-1:0] stamp_ms;
		logic              last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRESS_RD,
		ST_PRESS_EV,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic accept;
		logic press_rd;
		logic press_ev;
		logic scan;
		logic flush;
	} ctl_cmd_t;

	typedef struct packed {
		logic item_tick;
		logic scan_done;
	} ctl_sts_t;

endpackage

// ===== sv/pkctp_ctrl.sv =====
module pkctp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pkctp_pkg::ctl_sts_t sts,
	output pkctp_pkg::ctl_cmd_t cmd,
	output logic                busy
);
	import pkctp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = sts.item_tick ? ST_SCAN : ST_PRESS_RD;
				end
			end
			ST_PRESS_RD: state_nxt = ST_PRESS_EV;
			ST_PRESS_EV: state_nxt = ST_IDLE;
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		busy     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_PRESS_RD: cmd.press_rd = 1'b1;
			ST_PRESS_EV: cmd.press_ev = 1'b1;
			ST_SCAN:     cmd.scan     = 1'b1;
			ST_FLUSH:    cmd.flush    = 1'b1;
			default:     busy         = 1'b1;
		endcase
	end

endmodule

// ===== sv/pkctp_dpath.sv =====
`include "per_key_cooldown_tap_pulser_defines.svh"

module pkctp_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pkctp_pkg::item_t                    item,
	input  logic                                cfg_valid,
	input  logic [pkctp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pkctp_pkg::CFG_W-1:0]         cfg_data,
	input  pkctp_pkg::ctl_cmd_t                 cmd,
	output pkctp_pkg::ctl_sts_t                 sts,
	output pkctp_pkg::result_t                  result,
	output logic                                result_valid
);
	import pkctp_pkg::*;

	// Configuration.
	logic [CFG_W-1:0] cooldown_q;
	logic [CFG_W-1:0] tap_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= COOLDOWN_RST;
			tap_len_q  <= TAP_LEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COOLDOWN: cooldown_q <= cfg_data;
				CFG_TAP_LEN:  tap_len_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Captured item and time counter.
	item_t             item_q;
	logic [TIME_W-1:0] time_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (cmd.accept && item.func == FUNC_TICK) begin
			time_q <= time_q + 1'b1;
		end
	end

	logic [IDX_W-1:0] pos_idx;
	logic             pos_ok;

	assign pos_idx = IDX_W'(item_q.position);
	assign pos_ok  = 32'(item_q.position) < POSITIONS;

	// Scan counter and the one-stage evaluation pipeline behind the memory read.
	logic [CNT_W-1:0] scan_cnt_q;
	logic             eval_v_s1;
	logic [IDX_W-1:0] eval_idx_s1;
	logic             issue;

	assign issue = cmd.scan && (scan_cnt_q < POSITIONS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			eval_v_s1  <= 1'b0;
		end else begin
			eval_v_s1 <= issue;
			if (cmd.accept) begin
				scan_cnt_q <= '0;
			end else if (issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		eval_idx_s1 <= scan_cnt_q[IDX_W-1:0];
	end

	assign sts.item_tick = (item.func == FUNC_TICK);
	assign sts.scan_done = (scan_cnt_q == CNT_W'(POSITIONS)) && !eval_v_s1;

	// Slot storage. Last fire time reads as zero until its slot is first written.
	logic [TIME_W-1:0] lf_mem   [POSITIONS];
	logic [CODE_W-1:0] held_mem [POSITIONS];
	logic [TIME_W-1:0] due_mem  [POSITIONS];
	logic [POSITIONS-1:0] lf_valid_q;
	logic [POSITIONS-1:0] pressed_q;

	logic [IDX_W-1:0]  rd_addr;
	logic [TIME_W-1:0] lf_rd_q;
	logic [CODE_W-1:0] held_rd_q;
	logic [TIME_W-1:0] due_rd_q;

	logic [TIME_W-1:0] lf_eff;
	logic [TIME_W-1:0] since_fire;
	logic              fire;
	logic              set_due;
	logic [TIME_W-1:0] since_due;
	logic              hit;

	assign rd_addr    = cmd.press_rd ? pos_idx : scan_cnt_q[IDX_W-1:0];
	assign lf_eff     = lf_valid_q[pos_idx] ? lf_rd_q : '0;
	assign since_fire = time_q - lf_eff;
	assign fire       = cmd.press_ev && pos_ok && (since_fire >= TIME_W'(cooldown_q));
	assign set_due    = fire && !pressed_q[pos_idx];
	assign since_due  = time_q - due_rd_q;
	assign hit        = cmd.scan && eval_v_s1 && pressed_q[eval_idx_s1] &&
	                    !since_due[TIME_W-1];

	always_ff @(posedge clk) begin
		if (fire) begin
			lf_mem[pos_idx]   <= time_q;
			held_mem[pos_idx] <= item_q.keycode;
		end
		if (set_due) begin
			due_mem[pos_idx] <= time_q + TIME_W'(tap_len_q);
		end
		lf_rd_q   <= lf_mem[rd_addr];
		held_rd_q <= held_mem[rd_addr];
		due_rd_q  <= due_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lf_valid_q <= '0;
			pressed_q  <= '0;
		end else begin
			if (fire) begin
				lf_valid_q[pos_idx] <= 1'b1;
				pressed_q[pos_idx]  <= 1'b1;
			end
			if (hit) begin
				pressed_q[eval_idx_s1] <= 1'b0;
			end
		end
	end

	// A found release waits here until the next one shows it was not the final beat.
	logic              pend_valid_q;
	logic [CODE_W-1:0] pend_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (hit) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.flush) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			pend_code_q <= held_rd_q;
		end
	end

	// Output register.
	logic    emit;
	result_t emit_res;
	logic    out_valid_q;
	result_t out_q;

	always_comb begin
		emit     = 1'b0;
		emit_res = '0;
		priority if (fire) begin
			emit                 = 1'b1;
			emit_res.out_keycode = item_q.keycode;
			emit_res.is_press    = 1'b1;
			emit_res.stamp_ms    = time_q;
			emit_res.last        = 1'b1;
		end else if ((hit || cmd.flush) && pend_valid_q) begin
			emit                 = 1'b1;
			emit_res.out_keycode = pend_code_q;
			emit_res.is_press    = 1'b0;
			emit_res.stamp_ms    = time_q;
			emit_res.last        = cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`PKCTP_ASSERT_IMP(a_press_is_last, out_valid_q && out_q.is_press, out_q.last, "press beat not marked last")
	`PKCTP_ASSERT_IMP(a_release_stamp, out_valid_q && !out_q.is_press, out_q.stamp_ms == time_q, "release stamp differs from time counter")
	`PKCTP_ASSERT_IMP(a_scan_bound, 1'b1, scan_cnt_q <= CNT_W'(POSITIONS), "scan counter past slot count")
	`PKCTP_ASSERT_NXT(a_flush_clears, cmd.flush, !pend_valid_q, "pending release survives flush")

endmodule

// ===== sv/per_key_cooldown_tap_pulser.sv =====
// Press: accepted at one edge, busy in a read then an evaluate state, whose result is registered.
// Tick: slots are scanned in order, one slot memory read per cycle, then a flush state ends it.
// Releases of a tick appear one per cycle as due slots are found, the final beat after the scan.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) zeroes time, clears all pressed and fire-time flags at once,
// and restores the configuration defaults; there is no clearing pass.
module per_key_cooldown_tap_pulser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  pkctp_pkg::item_t                item,
	output pkctp_pkg::result_t              result,
	output logic                            result_valid,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pkctp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pkctp_pkg::CFG_W-1:0]     cfg_data
);
	import pkctp_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	assign cfg_ready = 1'b1;

	pkctp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	pkctp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

// Tracks the time counter and per-position slots, and holds the key events still owed.
class keyevent_board;
	logic [pkctp_pkg::TIME_W-1:0] now_ms;
	logic [pkctp_pkg::CFG_W-1:0]  cooldown;
	logic [pkctp_pkg::CFG_W-1:0]  tap_len;
	logic [pkctp_pkg::TIME_W-1:0] fired_at [pkctp_pkg::POSITIONS];
	logic [pkctp_pkg::CODE_W-1:0] code_held [pkctp_pkg::POSITIONS];
	logic [pkctp_pkg::TIME_W-1:0] due_at [pkctp_pkg::POSITIONS];
	bit                           held [pkctp_pkg::POSITIONS];
	pkctp_pkg::result_t           events_owed [$];
	int                           mismatches;

	function new();
		now_ms = '0;
		cooldown = pkctp_pkg::COOLDOWN_RST;
		tap_len = pkctp_pkg::TAP_LEN_RST;
		foreach (held[i]) begin
			fired_at[i] = '0;
			code_held[i] = '0;
			due_at[i] = '0;
			held[i] = 1'b0;
		end
		mismatches = 0;
	endfunction

	function void set_reg(logic [pkctp_pkg::CFG_IDX_W-1:0] idx, logic [pkctp_pkg::CFG_W-1:0] val);
		case (idx)
			pkctp_pkg::CFG_COOLDOWN: cooldown = val;
			pkctp_pkg::CFG_TAP_LEN:  tap_len = val;
			default: ;
		endcase
	endfunction

	function void take_item(pkctp_pkg::item_t it);
		logic [pkctp_pkg::TIME_W-1:0] age;
		int first_new;
		if (it.func == pkctp_pkg::FUNC_PRESS) begin
			age = now_ms - fired_at[it.position];
			if (age >= {16'd0, cooldown}) begin
				fired_at[it.position] = now_ms;
				code_held[it.position] = it.keycode;
				// A press on a slot that is still down keeps the earlier release deadline.
				if (!held[it.position])
					due_at[it.position] = now_ms + {16'd0, tap_len};
				held[it.position] = 1'b1;
				events_owed.push_back('{out_keycode: it.keycode, is_press: 1'b1,
					stamp_ms: now_ms, last: 1'b1});
			end
		end else begin
			now_ms = now_ms + 1;
			first_new = events_owed.size();
			for (int i = 0; i < pkctp_pkg::POSITIONS; i++) begin
				// Due once the wrapped distance past the deadline is non-negative.
				age = now_ms - due_at[i];
				if (held[i] && !age[pkctp_pkg::TIME_W-1]) begin
					held[i] = 1'b0;
					events_owed.push_back('{out_keycode: code_held[i], is_press: 1'b0,
						stamp_ms: now_ms, last: 1'b0});
				end
			end
			if (events_owed.size() > first_new)
				events_owed[events_owed.size()-1].last = 1'b1;
		end
	endfunction

	function void match_event(pkctp_pkg::result_t got);
		pkctp_pkg::result_t exp;
		if (events_owed.size() == 0) begin
			$error("unexpected key event: keycode %h is_press %0d stamp %0d",
				got.out_keycode, got.is_press, got.stamp_ms);
			mismatches++;
			return;
		end
		exp = events_owed.pop_front();
		if (got.out_keycode !== exp.out_keycode) begin
			$error("out_keycode: expected %h, actual %h", exp.out_keycode, got.out_keycode);
			mismatches++;
		end
		if (got.is_press !== exp.is_press) begin
			$error("is_press: expected %0d, actual %0d", exp.is_press, got.is_press);
			mismatches++;
		end
		if (got.stamp_ms !== exp.stamp_ms) begin
			$error("stamp_ms: expected %0d, actual %0d", exp.stamp_ms, got.stamp_ms);
			mismatches++;
		end
		if (got.last !== exp.last) begin
			$error("last: expected %0d, actual %0d", exp.last, got.last);
			mismatches++;
		end
	endfunction
endclass

module tb;
	import pkctp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = POSITIONS + 16;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	item_t                item = '0;
	result_t              result;
	logic                 result_valid;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	keyevent_board board = new();
	int            quiet_cycles = 0;
	bit            gaps_on = 1'b1;

	always #4 clk = ~clk;

	per_key_cooldown_tap_pulser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.match_event(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(input item_t it);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		board.take_item(it);
	endtask

	task automatic maybe_gap();
		int n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic press(input logic [POS_W-1:0] pos, input logic [CODE_W-1:0] code);
		maybe_gap();
		send('{func: FUNC_PRESS, position: pos, keycode: code});
	endtask

	task automatic tick();
		maybe_gap();
		// Position and keycode are don't-care on a tick; random values check that.
		send('{func: FUNC_TICK, position: POS_W'($urandom()), keycode: $urandom()});
	endtask

	// Lets every owed event arrive, then covers a tick that may still be scanning.
	task automatic settle();
		start <= 1'b0;
		while (board.events_owed.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_W-1:0] cool, input logic [CFG_W-1:0] tap);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_COOLDOWN;
		cfg_data <= cool;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(CFG_COOLDOWN, cool);
		cfg_index <= CFG_TAP_LEN;
		cfg_data <= tap;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(CFG_TAP_LEN, tap);
		cfg_valid <= 1'b0;
	endtask

	// Presses lean toward a cluster of span + 1 positions so that cooldowns and
	// re-presses on a held key come up often.
	task automatic random_phase(input int count, input int span);
		int base;
		int p;
		base = $urandom_range(0, POSITIONS - 1);
		repeat (count) begin
			if ($urandom_range(0, 99) < 40) begin
				tick();
			end else begin
				if ($urandom_range(0, 1) == 1)
					p = (base + $urandom_range(0, span)) % POSITIONS;
				else
					p = $urandom_range(0, POSITIONS - 1);
				press(POS_W'(p), $urandom());
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: early presses fall inside the cooldown.
		press(6'd0, 32'h0000_0000);
		tick();
		press(6'd63, 32'hFFFF_FFFF);
		settle();

		// No cooldown, zero tap length: release on the very next tick.
		write_cfg(16'd0, 16'd0);
		press(6'd0, 32'hFFFF_FFFF);
		press(6'd63, 32'h0000_0000);
		press(6'd0, 32'hA5A5_5A5A);
		tick();
		tick();
		settle();

		write_cfg(16'd3, 16'd2);
		press(6'd10, 32'h8000_0001);
		press(6'd10, 32'h0000_0001);
		tick();
		tick();
		tick();
		press(6'd10, 32'h0000_0002);
		press(6'd42, 32'h7FFF_FFFF);
		tick();
		tick();
		settle();

		// Longest tap: this key stays down for the rest of the run.
		write_cfg(16'd0, 16'hFFFF);
		press(6'd62, 32'h0000_FFFF);
		press(6'd62, 32'hFFFF_0000);
		tick();
		settle();

		write_cfg(16'd1, 16'd1);
		random_phase(80, 7);
		settle();
		write_cfg(16'd4, 16'd3);
		random_phase(80, 3);
		settle();
		write_cfg(16'd0, 16'd8);
		random_phase(80, 15);
		settle();
		write_cfg(16'hFFFF, 16'd5);
		random_phase(20, 7);
		settle();
		write_cfg(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 15)));
		random_phase(80, 5);
		settle();
		write_cfg(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 15)));
		random_phase(80, 63);
		settle();

		gaps_on = 1'b0;
		write_cfg(16'd2, 16'd4);
		random_phase(80, 7);
		settle();

		if (board.mismatches == 0 && board.events_owed.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
